// File: design/assert_macros.svh
// Assertion macros shared by the design files.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KVT_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define KVT_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/kvt_pkg.sv
// Package for keyed_value_table: request and status codes, field widths.
// No dependencies.
package kvt_pkg;

    localparam int OP_W     = 3;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_INSERT = 3'd1,
        OP_ERASE  = 3'd2,
        OP_LOOKUP = 3'd3,
        OP_COUNT  = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_PRESENT = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

endpackage

// File: design/keyed_value_table.sv
// keyed_value_table: unsorted key/value table with linear search.
// Depends on kvt_pkg and assert_macros.svh.
//
// A request word is taken when start is high and busy is low; exactly one result word
// follows, shown for one cycle with o_valid, and it cannot be held off. Clear, unused op
// codes, refused inserts into a full table and any request on an empty table answer in
// the cycle after acceptance without raising busy. Other requests scan the key and value
// memories through their single read port, one entry per cycle: the result follows the
// compare of the last filled entry, sooner for a lookup, insert or erase that hits early,
// and an erase that hits then passes through S_ERASE_RD and S_ERASE_WR to move the last
// entry into the freed slot. A new request may be issued in the cycle its predecessor's
// result is shown.
`include "assert_macros.svh"

module keyed_value_table #(
    parameter int TABLE_DEPTH = 32,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [kvt_pkg::OP_W-1:0]      i_op,
    input  logic [kvt_pkg::KEY_W-1:0]     i_key_in,
    input  logic [kvt_pkg::VALUE_W-1:0]   i_value_in,
    output logic                          o_valid,
    output logic [kvt_pkg::STATUS_W-1:0]  o_status,
    output logic [kvt_pkg::VALUE_W-1:0]   o_value_out,
    output logic [kvt_pkg::COUNT_W-1:0]   o_match_count,
    output logic [kvt_pkg::COUNT_W-1:0]   o_entries_used
);
    import kvt_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ERASE_RD,
        S_ERASE_WR
    } t_state;

    logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0]   r_key_q;
    logic [VALUE_BITS-1:0] r_val_q;

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [CNT_W-1:0]      r_fill, n_fill;
    logic [CNT_W-1:0]      r_ptr, n_ptr;
    logic [CNT_W-1:0]      r_chk, n_chk;
    logic                  r_vld, n_vld;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [ADDR_W-1:0]     r_slot, n_slot;

    logic                  r_valid, n_valid;
    t_status               r_status, n_status;
    logic [VALUE_W-1:0]    r_value_out, n_value_out;
    logic [COUNT_W-1:0]    r_match, n_match;
    logic [COUNT_W-1:0]    r_entries, n_entries;

    logic [ADDR_W-1:0]     rd_addr;
    logic                  we;
    logic [ADDR_W-1:0]     wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_val;

    logic                  key_hit, val_hit, last;
    logic [CNT_W-1:0]      cnt_next;
    logic [CNT_W-1:0]      fill_m1;
    logic [KEY_BITS-1:0]   in_key;
    logic [VALUE_BITS-1:0] in_val;

    assign in_key   = KEY_BITS'(i_key_in);
    assign in_val   = VALUE_BITS'(i_value_in);
    assign fill_m1  = CNT_W'(r_fill - CNT_W'(1));
    assign key_hit  = (r_key_q == r_key);
    assign val_hit  = (r_val_q == r_val);
    assign last     = (r_chk == fill_m1);
    assign cnt_next = CNT_W'(r_cnt + CNT_W'(val_hit));

    always_ff @(posedge i_clk) begin
        r_key_q <= key_mem[rd_addr];
        r_val_q <= val_mem[rd_addr];
        if (we) begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_val       = r_val;
        n_fill      = r_fill;
        n_ptr       = r_ptr;
        n_chk       = r_chk;
        n_vld       = r_vld;
        n_cnt       = r_cnt;
        n_slot      = r_slot;
        n_valid     = 1'b0;
        n_status    = ST_DONE;
        n_value_out = '0;
        n_match     = '0;
        rd_addr     = r_ptr[ADDR_W-1:0];
        we          = 1'b0;
        wr_addr     = r_fill[ADDR_W-1:0];
        wr_key      = r_key;
        wr_val      = r_val;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = t_op'(i_op);
                    n_key = in_key;
                    n_val = in_val;
                    n_ptr = '0;
                    n_vld = 1'b0;
                    n_cnt = '0;
                    case (i_op)
                        OP_CLEAR: begin
                            n_fill  = '0;
                            n_valid = 1'b1;
                        end
                        OP_INSERT: begin
                            if (r_fill == CNT_W'(TABLE_DEPTH)) begin
                                n_valid  = 1'b1;
                                n_status = ST_FULL;
                            end else if (r_fill == '0) begin
                                we      = 1'b1;
                                wr_key  = in_key;
                                wr_val  = in_val;
                                n_fill  = CNT_W'(r_fill + CNT_W'(1));
                                n_valid = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_ERASE, OP_LOOKUP: begin
                            if (r_fill == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_MISSING;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_COUNT: begin
                            if (r_fill == '0) begin
                                n_valid = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_ptr < r_fill) begin
                    n_ptr = CNT_W'(r_ptr + CNT_W'(1));
                    n_chk = r_ptr;
                    n_vld = 1'b1;
                end else begin
                    n_vld = 1'b0;
                end
                if (r_vld) begin
                    case (r_op)
                        OP_COUNT: begin
                            n_cnt = cnt_next;
                            if (last) begin
                                n_valid = 1'b1;
                                n_match = COUNT_W'(cnt_next);
                                n_state = S_IDLE;
                            end
                        end
                        OP_INSERT: begin
                            if (key_hit) begin
                                n_valid  = 1'b1;
                                n_status = ST_PRESENT;
                                n_state  = S_IDLE;
                            end else if (last) begin
                                we      = 1'b1;
                                n_fill  = CNT_W'(r_fill + CNT_W'(1));
                                n_valid = 1'b1;
                                n_state = S_IDLE;
                            end
                        end
                        OP_LOOKUP: begin
                            if (key_hit) begin
                                n_valid     = 1'b1;
                                n_value_out = VALUE_W'(r_val_q);
                                n_state     = S_IDLE;
                            end else if (last) begin
                                n_valid  = 1'b1;
                                n_status = ST_MISSING;
                                n_state  = S_IDLE;
                            end
                        end
                        OP_ERASE: begin
                            if (key_hit) begin
                                n_slot  = r_chk[ADDR_W-1:0];
                                n_state = S_ERASE_RD;
                            end else if (last) begin
                                n_valid  = 1'b1;
                                n_status = ST_MISSING;
                                n_state  = S_IDLE;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ERASE_RD: begin
                rd_addr = fill_m1[ADDR_W-1:0];
                n_state = S_ERASE_WR;
            end
            S_ERASE_WR: begin
                // move the last entry into the freed slot
                we      = 1'b1;
                wr_addr = r_slot;
                wr_key  = r_key_q;
                wr_val  = r_val_q;
                n_fill  = fill_m1;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_entries = COUNT_W'(n_fill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_vld   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_vld   <= n_vld;
            r_valid <= n_valid;
        end
        r_op        <= n_op;
        r_key       <= n_key;
        r_val       <= n_val;
        r_ptr       <= n_ptr;
        r_chk       <= n_chk;
        r_cnt       <= n_cnt;
        r_slot      <= n_slot;
        r_status    <= n_status;
        r_value_out <= n_value_out;
        r_match     <= n_match;
        r_entries   <= n_entries;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_value_out    = r_value_out;
    assign o_match_count  = r_match;
    assign o_entries_used = r_entries;

    `KVT_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= CNT_W'(TABLE_DEPTH))
    `KVT_ASSERT_IMP(a_result_idle, o_valid, !busy)
    `KVT_ASSERT_NXT(a_accept_progress, start && !busy, busy || o_valid)
    `KVT_ASSERT_IMP(a_full_status, o_valid && (o_status == ST_FULL), r_fill == CNT_W'(TABLE_DEPTH))
    `KVT_ASSERT_IMP(a_scan_in_range, r_state == S_SCAN && r_vld, r_chk < r_fill)

endmodule
